// ===== rtl/core/trle_pkg.sv =====
// Shared types and constants for the tga rle pixel decoder.
// No dependencies; used by the channel interfaces and every module of the block.
package trle_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PixelW  = 32;
  localparam int unsigned RepeatW = 8;
  localparam int unsigned BppW    = 3;
  localparam int unsigned CountW  = 30;
  localparam int unsigned PosW    = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 30;

  // packet byte coding
  localparam int unsigned RunFlagBit = 7;
  localparam logic [RepeatW-1:0] MaxPacket = 8'd128;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BYTES_PER_PIXEL = 1'b0,
    CFG_PIXEL_COUNT     = 1'b1
  } cfg_reg_e;

  // reset values of the configuration registers
  localparam logic [BppW-1:0]   BppReset   = 3'd4;
  localparam logic [CountW-1:0] CountReset = 30'd1;

  // configuration seen by the decode logic
  typedef struct packed {
    logic [BppW-1:0]   bytes_per_pixel;
    logic [CountW-1:0] pixel_count;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [PixelW-1:0]  pixel_value;
    logic [RepeatW-1:0] repeat_count;
    logic               last_pixel;
  } res_t;

  // handshake between the decode logic and the output register
  typedef struct packed {
    logic               res_valid;
    res_t               res;
  } res_req_t;

  // depth clamped to 1..4
  function automatic logic [BppW-1:0] eff_bpp(input logic [BppW-1:0] bpp);
    logic [BppW-1:0] r;
    if (bpp == '0) begin
      r = 3'd1;
    end else if (bpp > 3'd4) begin
      r = 3'd4;
    end else begin
      r = bpp;
    end
    return r;
  endfunction

  // swap bytes zero and two
  function automatic logic [PixelW-1:0] rgb_swap(input logic [PixelW-1:0] px);
    return {px[31:24], px[7:0], px[15:8], px[23:16]};
  endfunction

endpackage

// ===== rtl/core/trle_if.sv =====
// Valid/ready channel interfaces of the tga rle pixel decoder.
// Depends on trle_pkg for the payload types and widths.

// compressed byte stream
interface trle_byte_if
  import trle_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// decoded pixel stream
interface trle_pix_if
  import trle_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [PixelW-1:0]  pixel_value;
  logic [RepeatW-1:0] repeat_count;
  logic               last_pixel;

  modport source (output valid, output pixel_value, output repeat_count,
                  output last_pixel, input ready);
  modport sink   (input valid, input pixel_value, input repeat_count,
                  input last_pixel, output ready);
endinterface

// configuration register writes
interface trle_cfg_if
  import trle_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/core/trle_in_reg.sv =====
// Input register of the tga rle pixel decoder: holds one byte for the decode stage.
// Depends on trle_pkg and trle_byte_if.
module trle_in_reg
  import trle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  trle_byte_if.sink        byte_i,
  input  logic             take_i,
  output logic             valid_o,
  output logic [ByteW-1:0] data_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] data_q, data_d;
  logic             load;

  // free when empty or when the held byte leaves this cycle
  assign byte_i.ready = !valid_q || take_i;
  assign load         = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = byte_i.data_byte;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/trle_core.sv =====
// Decode stage of the tga rle pixel decoder: packet parsing, pixel gathering,
// count clipping and image end. Depends on trle_pkg.
module trle_core
  import trle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             byte_valid_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             out_space_i,
  output logic             byte_taken_o,
  output res_req_t         req_o
);

  logic                expect_q, expect_d;
  logic                run_q, run_d;
  logic [RepeatW-1:0]  left_q, left_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [PixelW-1:0]   gather_q, gather_d;
  logic [CountW-1:0]   done_q, done_d;

  logic [BppW-1:0]     bpp;
  logic [CountW-1:0]   total;
  logic [PixelW-1:0]   gathered;
  logic                pix_done;
  logic [PixelW-1:0]   px;
  logic [CountW-1:0]   remaining;
  logic [RepeatW-1:0]  run_len;
  logic [RepeatW-1:0]  rep_raw;
  logic                last;
  logic [RepeatW-1:0]  rep_out;
  logic [RepeatW-1:0]  left_next;
  logic                step;

  // per-byte decode and state update
  always_comb begin
    expect_d = expect_q;
    run_d    = run_q;
    left_d   = left_q;
    pos_d    = pos_q;
    gather_d = gather_q;
    done_d   = done_q;

    bpp      = eff_bpp(cfg_i.bytes_per_pixel);
    total    = (cfg_i.pixel_count == '0) ? CountW'(1) : cfg_i.pixel_count;
    gathered = gather_q | (PixelW'(byte_i) << {pos_q, 3'b000});
    pix_done = (BppW'(pos_q) + BppW'(1)) >= bpp;
    px       = (bpp >= 3'd3) ? rgb_swap(gathered) : gathered;

    // pixels still owed to the image, at least one
    remaining = (total > done_q) ? (total - done_q) : CountW'(1);
    if (left_q == '0) begin
      run_len = 8'd1;
    end else if (left_q > MaxPacket) begin
      run_len = MaxPacket;
    end else begin
      run_len = left_q;
    end
    rep_raw = run_q ? run_len : 8'd1;
    // the image ends once the clipped count reaches the remaining pixels
    last    = CountW'(rep_raw) >= remaining;
    rep_out = last ? remaining[RepeatW-1:0] : rep_raw;

    left_next = run_q ? '0 : ((left_q != '0) ? (left_q - 8'd1) : '0);

    req_o.res_valid        = !expect_q && pix_done;
    req_o.res.pixel_value  = px;
    req_o.res.repeat_count = rep_out;
    req_o.res.last_pixel   = last;

    step = byte_valid_i && (!req_o.res_valid || out_space_i);

    if (step) begin
      if (expect_q) begin
        // packet byte
        run_d    = byte_i[RunFlagBit];
        left_d   = {1'b0, byte_i[RunFlagBit-1:0]} + 8'd1;
        pos_d    = '0;
        gather_d = '0;
        expect_d = 1'b0;
      end else if (!pix_done) begin
        gather_d = gathered;
        pos_d    = pos_q + PosW'(1);
      end else begin
        // pixel complete
        pos_d    = '0;
        gather_d = '0;
        left_d   = left_next;
        expect_d = (left_next == '0);
        if (last) begin
          done_d   = '0;
          left_d   = '0;
          expect_d = 1'b1;
        end else begin
          done_d = done_q + CountW'(rep_out);
        end
      end
    end
  end

  assign byte_taken_o = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b1;
      run_q    <= 1'b0;
      left_q   <= '0;
      pos_q    <= '0;
      gather_q <= '0;
      done_q   <= '0;
    end else begin
      expect_q <= expect_d;
      run_q    <= run_d;
      left_q   <= left_d;
      pos_q    <= pos_d;
      gather_q <= gather_d;
      done_q   <= done_d;
    end
  end

endmodule

// ===== rtl/core/trle_out_reg.sv =====
// Result register of the tga rle pixel decoder: holds one item for the sink.
// Depends on trle_pkg and trle_pix_if.
module trle_out_reg
  import trle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_req_t   req_i,
  input  logic       load_i,
  output logic       space_o,
  trle_pix_if.source pix_o
);

  logic valid_q, valid_d;
  res_t res_q, res_d;

  // room when empty or when the held item is taken this cycle
  assign space_o = !valid_q || pix_o.ready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i && req_i.res_valid) begin
      valid_d = 1'b1;
      res_d   = req_i.res;
    end else if (pix_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign pix_o.valid        = valid_q;
  assign pix_o.pixel_value  = res_q.pixel_value;
  assign pix_o.repeat_count = res_q.repeat_count;
  assign pix_o.last_pixel   = res_q.last_pixel;

endmodule

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// Decodes the run-length pixel data of a tga image, one compressed byte per
// item, and emits one item per run (pixel plus repeat count) or per raw pixel
// (count one), bytes zero and two swapped at three or four bytes per pixel,
// the item that completes pixel_count pixels flagged last. One byte is
// accepted every cycle while the output side keeps up; a byte passes an input
// register, then the decode logic, then the result register, which is loaded
// as the byte that completes a pixel is taken. Registers are written through
// the cfg port, always ready, and take effect at once.
// Depends on trle_pkg, trle_if, trle_in_reg, trle_core and trle_out_reg.
module tga_rle_pixel_decoder
  import trle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  trle_cfg_if.sink   cfg_i,
  trle_byte_if.sink  byte_in_i,
  trle_pix_if.source pix_out_o
);

  logic [BppW-1:0]  bytes_per_pixel_q;
  logic [CountW-1:0] pixel_count_q;
  cfg_t             cfg;
  logic             byte_valid;
  logic [ByteW-1:0] byte_data;
  logic             byte_taken;
  logic             out_space;
  res_req_t         req;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_per_pixel_q <= BppReset;
      pixel_count_q     <= CountReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.reg_index))
        CFG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_i.wdata[BppW-1:0];
        CFG_PIXEL_COUNT:     pixel_count_q     <= cfg_i.wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.bytes_per_pixel = bytes_per_pixel_q;
  assign cfg.pixel_count     = pixel_count_q;

  // input register
  trle_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_in_i),
    .take_i  (byte_taken),
    .valid_o (byte_valid),
    .data_o  (byte_data)
  );

  // decode stage
  trle_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_data),
    .out_space_i  (out_space),
    .byte_taken_o (byte_taken),
    .req_o        (req)
  );

  // result register
  trle_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .load_i  (byte_taken),
    .space_o (out_space),
    .pix_o   (pix_out_o)
  );

endmodule
